@@ hw/rtl/jqfbc_pkg.sv @@
`default_nettype none

package jqfbc_pkg;

  // Fixed field widths
  localparam int unsigned ID_W     = 16;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned QCOUNT_W = 5;

  // Default queue depth
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Command codes
  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CANCEL = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ID_W-1:0]     job_id;
    logic [HANDLE_W-1:0] doc_handle;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QCOUNT_W-1:0] queue_count;
    logic                front_valid;
    logic [ID_W-1:0]     front_id;
    logic [HANDLE_W-1:0] front_doc;
  } result_t;

  // One stored job
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] doc;
  } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/job_queue_front_back_cancel.sv @@
`default_nettype none

// Job queue with append at back, urgent insert at front and cancel by id.
// Request channel: drive cmd and raise start; the request is taken at a
// rising edge with start high and busy low. busy stays high until the reply.
// Reply channel: done is high for exactly one cycle with result valid; the
// receiver cannot stall, so it must take the reply in that cycle.
// Jobs live in one ring-addressed memory (one write, one registered read).
// Sequence from the accept edge: append, insert, refused push, unused opcode
// and cancel on an empty queue pass through a front read state and a reply
// state; busy stays high meanwhile, so a new request waits until the reply.
// Cancel walks the queue one entry per cycle through the read port: a search
// walk, then, only if the id is found, a close-up walk of the jobs behind it,
// then the front read and the reply; the single read port sets this walk.
// Reset (rst, synchronous) empties the queue; memory contents are not
// cleared, entries beyond the count never reach the reply.
module job_queue_front_back_cancel #(
  parameter int unsigned QUEUE_DEPTH = jqfbc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  jqfbc_pkg::cmd_t    cmd,
  output logic               busy,
  output logic               done,
  output jqfbc_pkg::result_t result
);
  import jqfbc_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  logic          rd_en;
  logic [PW-1:0] rd_idx;
  logic          wr_en;
  logic          wr_front;
  logic [PW-1:0] wr_idx;
  entry_t        wr_data;
  entry_t        rd_data;

  // Sequencer
  jqfbc_ctrl #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .wr_en    (wr_en),
    .wr_front (wr_front),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data),
    .rd_data  (rd_data)
  );

  // Ring store
  jqfbc_ring #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .wr_en    (wr_en),
    .wr_front (wr_front),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data),
    .rd_data  (rd_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/jqfbc_ring.sv @@
`default_nettype none

module jqfbc_ring #(
  parameter int unsigned DEPTH = jqfbc_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [PW-1:0]     rd_idx,
  input  logic              wr_en,
  input  logic              wr_front,
  input  logic [PW-1:0]     wr_idx,
  input  jqfbc_pkg::entry_t wr_data,
  output jqfbc_pkg::entry_t rd_data
);
  import jqfbc_pkg::*;

  entry_t        mem [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] head_dec;
  logic [PW-1:0] wr_addr;
  logic [PW-1:0] rd_addr;

  // Logical slot (from the front) to physical address, wrapping at DEPTH
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base, input logic [PW-1:0] idx);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  // Slot in front of the current head
  always_comb begin
    if (head == '0) begin
      head_dec = PW'(DEPTH - 1);
    end else begin
      head_dec = head - 1'b1;
    end
  end

  assign wr_addr = wr_front ? head_dec : phys(head, wr_idx);
  assign rd_addr = phys(head, rd_idx);

  // Head pointer moves back on an urgent insert
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (wr_en && wr_front) begin
      head <= head_dec;
    end
  end

  // Job store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/jqfbc_ctrl.sv @@
`default_nettype none

module jqfbc_ctrl #(
  parameter int unsigned DEPTH = jqfbc_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  jqfbc_pkg::cmd_t    cmd,
  output logic               busy,
  output logic               done,
  output jqfbc_pkg::result_t result,
  output logic               rd_en,
  output logic [PW-1:0]      rd_idx,
  output logic               wr_en,
  output logic               wr_front,
  output logic [PW-1:0]      wr_idx,
  output jqfbc_pkg::entry_t  wr_data,
  input  jqfbc_pkg::entry_t  rd_data
);
  import jqfbc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_FRONT  = 5'b01000,
    S_REPLY  = 5'b10000
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       scan;
  logic [PW-1:0]       chk;
  logic                chk_valid;
  logic [ID_W-1:0]     key;
  logic [STATUS_W-1:0] status;

  logic full;
  logic more;
  logic match;

  assign full  = (count == CW'(DEPTH));
  assign more  = (scan < count);
  assign match = chk_valid && (rd_data.id == key);
  assign busy  = (state != S_IDLE);
  assign done  = (state == S_REPLY);

  // Result fields; front job comes from the read issued in S_FRONT
  always_comb begin
    result.status      = status;
    result.queue_count = QCOUNT_W'(count);
    result.front_valid = (count != '0);
    result.front_id    = (count != '0) ? rd_data.id  : '0;
    result.front_doc   = (count != '0) ? rd_data.doc : '0;
  end

  // Memory requests
  always_comb begin
    rd_en    = 1'b0;
    rd_idx   = scan[PW-1:0];
    wr_en    = 1'b0;
    wr_front = 1'b0;
    wr_idx   = '0;
    wr_data  = '{id: cmd.job_id, doc: cmd.doc_handle};
    case (state)
      S_IDLE: begin
        if (start && !full) begin
          if (cmd.opcode == OP_APPEND) begin
            wr_en  = 1'b1;
            wr_idx = count[PW-1:0];
          end else if (cmd.opcode == OP_INSERT) begin
            wr_en    = 1'b1;
            wr_front = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        rd_en = more;
      end
      S_SHIFT: begin
        // entry chk moves forward into slot chk-1
        rd_en = more;
        if (chk_valid) begin
          wr_en   = 1'b1;
          wr_idx  = chk - 1'b1;
          wr_data = rd_data;
        end
      end
      S_FRONT: begin
        rd_en  = 1'b1;
        rd_idx = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: search walk, close-up walk, front read, reply
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            status    <= ST_OK;
            key       <= cmd.job_id;
            scan      <= '0;
            chk_valid <= 1'b0;
            state     <= S_FRONT;
            if (cmd.opcode inside {OP_APPEND, OP_INSERT}) begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                count <= count + 1'b1;
              end
            end else if (cmd.opcode == OP_CANCEL) begin
              if (count == '0) begin
                status <= ST_NOT_FOUND;
              end else begin
                state <= S_SEARCH;
              end
            end
          end
        end
        S_SEARCH: begin
          if (more) begin
            scan <= scan + 1'b1;
          end
          chk_valid <= more;
          chk       <= scan[PW-1:0];
          if (match) begin
            state <= S_SHIFT;
          end else if (!chk_valid && !more) begin
            status <= ST_NOT_FOUND;
            state  <= S_FRONT;
          end
        end
        S_SHIFT: begin
          if (more) begin
            scan <= scan + 1'b1;
          end
          chk_valid <= more;
          chk       <= scan[PW-1:0];
          if (!chk_valid) begin
            count <= count - 1'b1;
            state <= S_FRONT;
          end
        end
        S_FRONT: begin
          state <= S_REPLY;
        end
        S_REPLY: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A reply always follows the front read
  a_reply_after_front: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FRONT))
    else $error("reply without front read");

  // An accepted request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Full status only when the queue really is full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> (count == CW'(DEPTH)))
    else $error("full status with room left");

  // Count moves only on acceptance or at the end of a close-up
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_SHIFT) |=> $stable(count))
    else $error("count changed outside update points");

  // An append write is never issued into a full queue
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wr_en && !wr_front && state == S_IDLE |-> (count < CW'(DEPTH)))
    else $error("append into a full queue");

endmodule

`default_nettype wire

@@ tb/job_queue_front_back_cancel_tb.sv @@
`timescale 1ns / 100ps

module job_queue_front_back_cancel_tb;
  import jqfbc_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int RANDOM_REQUESTS = 1400;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = DEPTH + 8;
  localparam int MAX_REPORTS = 10;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  result_t reply;

  // Shadow of the job queue, updated as each request is taken
  logic [ID_W-1:0] shadow_ids [DEPTH];
  logic [HANDLE_W-1:0] shadow_docs [DEPTH];
  int held_jobs = 0;

  result_t pending_replies[$];
  int mismatches = 0;
  int stall_cycles = 0;

  job_queue_front_back_cancel #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(reply)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one request to the shadow queue and return the reply it should give
  function automatic result_t apply_request(cmd_t c);
    result_t r;
    int i;
    int hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    case (c.opcode)
      OP_APPEND: begin
        if (held_jobs >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_ids[held_jobs] = c.job_id;
          shadow_docs[held_jobs] = c.doc_handle;
          held_jobs++;
        end
      end
      OP_INSERT: begin
        if (held_jobs >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = held_jobs; i > 0; i--) begin
            shadow_ids[i] = shadow_ids[i-1];
            shadow_docs[i] = shadow_docs[i-1];
          end
          shadow_ids[0] = c.job_id;
          shadow_docs[0] = c.doc_handle;
          held_jobs++;
        end
      end
      OP_CANCEL: begin
        // first match from the front wins
        for (i = 0; i < held_jobs; i++)
          if (hit < 0 && shadow_ids[i] == c.job_id) hit = i;
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = hit; i + 1 < held_jobs; i++) begin
            shadow_ids[i] = shadow_ids[i+1];
            shadow_docs[i] = shadow_docs[i+1];
          end
          held_jobs--;
        end
      end
      default: ;
    endcase
    r.queue_count = QCOUNT_W'(held_jobs);
    if (held_jobs > 0) begin
      r.front_valid = 1'b1;
      r.front_id = shadow_ids[0];
      r.front_doc = shadow_docs[0];
    end
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [OPCODE_W-1:0] op, logic [ID_W-1:0] id,
                                    logic [HANDLE_W-1:0] doc);
    cmd_t c;
    c.opcode = op;
    c.job_id = id;
    c.doc_handle = doc;
    return c;
  endfunction

  // Mostly no gap, some short, a few long; no gap at all when gaps are off
  function automatic int pick_gap(bit allow);
    int r;
    r = $urandom_range(0, 99);
    if (!allow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Ids from a narrow pool give duplicates and cancel hits
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 1)) return ID_W'($urandom_range(0, 7));
    return ID_W'($urandom());
  endfunction

  // Send one request; start is left high so a back-to-back request needs no drop
  task automatic issue_request(cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_replies.push_back(apply_request(c));
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Reply checker and stall watchdog
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (done === 1'b1 || (start && busy === 1'b0)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
      if (done === 1'b1) begin
        if (pending_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t reply with no request outstanding: %h", $realtime, reply);
        end else begin
          want = pending_replies.pop_front();
          report_field("status", want.status, reply.status);
          report_field("queue_count", want.queue_count, reply.queue_count);
          report_field("front_valid", want.front_valid, reply.front_valid);
          report_field("front_id", want.front_id, reply.front_id);
          report_field("front_doc", want.front_doc, reply.front_doc);
        end
      end
    end
  end

  // Empty queue, only-job removal, both ends, duplicates, unused opcode
  task automatic test_basic_ops();
    issue_request(make_cmd(OP_CANCEL, 16'd5, 16'h0000), 0);
    issue_request(make_cmd(OP_UNUSED, 16'hffff, 16'hffff), 0);
    issue_request(make_cmd(OP_APPEND, 16'd42, 16'd7), 0);
    issue_request(make_cmd(OP_CANCEL, 16'd42, 16'hffff), 2);
    issue_request(make_cmd(OP_APPEND, 16'h0000, 16'h0000), 0);
    issue_request(make_cmd(OP_APPEND, 16'hffff, 16'hffff), 0);
    issue_request(make_cmd(OP_INSERT, 16'h1234, 16'habcd), 1);
    issue_request(make_cmd(OP_APPEND, 16'h1234, 16'h1111), 0);
    issue_request(make_cmd(OP_CANCEL, 16'h1234, 16'h0000), 0);
    issue_request(make_cmd(OP_UNUSED, 16'h5555, 16'haaaa), 0);
    issue_request(make_cmd(OP_CANCEL, 16'h7777, 16'h0000), 3);
    issue_request(make_cmd(OP_CANCEL, 16'hffff, 16'h0000), 0);
  endtask

  // Fill up, refused pushes, a missed cancel, then cancel at the back of the full queue and at the front
  task automatic test_full_queue();
    int k;
    k = 0;
    while (held_jobs < DEPTH) begin
      issue_request(make_cmd(k[0] ? OP_INSERT : OP_APPEND, ID_W'(16'h8000 + k),
                             HANDLE_W'(16'h4000 + k)), 0);
      k++;
    end
    issue_request(make_cmd(OP_APPEND, 16'haaaa, 16'h5555), 0);
    issue_request(make_cmd(OP_INSERT, 16'h5555, 16'haaaa), 0);
    issue_request(make_cmd(OP_CANCEL, 16'h7777, 16'h0000), 0);
    issue_request(make_cmd(OP_CANCEL, shadow_ids[DEPTH-1], 16'h0000), 0);
    issue_request(make_cmd(OP_CANCEL, shadow_ids[0], 16'h0000), 0);
  endtask

  // Random traffic in phases that grow, shrink and hover, with some gap-free stretches
  task automatic test_random_traffic(int count);
    int n;
    int r;
    int phase;
    bit gaps_on;
    logic [OPCODE_W-1:0] op;
    logic [ID_W-1:0] id;
    for (n = 0; n < count; n++) begin
      phase = (n / 100) % 3;
      gaps_on = ((n / 100) % 4) != 3;
      r = $urandom_range(0, 99);
      if (r < 5) op = OP_UNUSED;
      else if (phase == 0) op = (r < 45) ? OP_APPEND : (r < 80) ? OP_INSERT : OP_CANCEL;
      else if (phase == 1) op = (r < 20) ? OP_APPEND : (r < 30) ? OP_INSERT : OP_CANCEL;
      else op = (r < 35) ? OP_APPEND : (r < 60) ? OP_INSERT : OP_CANCEL;
      id = pick_id();
      if (op == OP_CANCEL && held_jobs > 0 && $urandom_range(0, 99) < 80)
        id = shadow_ids[$urandom_range(0, held_jobs - 1)];
      issue_request(make_cmd(op, id, HANDLE_W'($urandom())), pick_gap(gaps_on));
      // hold off now and then until every reply is back
      if (n % 350 == 349) drain_replies();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_full_queue();
    drain_replies();
    test_random_traffic(RANDOM_REQUESTS);
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/jqfbc_pkg.sv
hw/rtl/jqfbc_ring.sv
hw/rtl/jqfbc_ctrl.sv
hw/rtl/job_queue_front_back_cancel.sv
tb/job_queue_front_back_cancel_tb.sv
